### hw/rtl/mm3h_pkg.sv
// ----------------------------------------------------------------------------
// mm3h_pkg
// shared types and constants of the murmur3 x86_32 stream hash
// ----------------------------------------------------------------------------
package mm3h_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned NvW     = 3;
	localparam int unsigned InDataW = 40;

	localparam logic [WordW-1:0] MixC1  = 32'hcc9e2d51;
	localparam logic [WordW-1:0] MixC2  = 32'h1b873593;
	localparam logic [WordW-1:0] FoldN  = 32'he6546b64;
	localparam logic [WordW-1:0] FinF1  = 32'h85ebca6b;
	localparam logic [WordW-1:0] FinF2  = 32'hc2b2ae35;
	localparam logic [NvW-1:0]   FullNv = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MIX,
		ST_FIN0,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mix;
		logic fin0;
		logic fin1;
		logic fin2;
		logic fin_out;
	} cmd_t;

	typedef struct packed {
		logic in_last;
		logic in_has_bytes;
		logic key_fin;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/mm3h_ctrl.sv
// ----------------------------------------------------------------------------
// mm3h_ctrl
// sequencer stepping one item through block mix and finalization
// ----------------------------------------------------------------------------
module mm3h_ctrl
	import mm3h_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (!sts.in_last || sts.in_has_bytes) begin
						state_d = ST_MUL1;
					end else begin
						state_d = ST_FIN0;
					end
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MIX;
			ST_MIX: begin
				state_d = sts.key_fin ? ST_FIN0 : ST_IDLE;
			end
			ST_FIN0: state_d = ST_FIN1;
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_FIN3;
			ST_FIN3: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_MIX:  cmd.mix  = 1'b1;
			ST_FIN0: cmd.fin0 = 1'b1;
			ST_FIN1: cmd.fin1 = 1'b1;
			ST_FIN2: cmd.fin2 = 1'b1;
			ST_FIN3: cmd.fin_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/mm3h_datapath.sv
// ----------------------------------------------------------------------------
// mm3h_datapath
// seed, running hash, byte count, block mix and avalanche registers
// ----------------------------------------------------------------------------
module mm3h_datapath
	import mm3h_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [InDataW-1:0] s_tdata,
	input  logic               s_tlast,
	input  logic               cfg_valid,
	input  logic [WordW-1:0]   cfg_data,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [WordW-1:0]   m_tdata,
	input  cmd_t               cmd,
	output sts_t               sts
);

	logic [WordW-1:0] seed_q;
	logic [WordW-1:0] hash_q;
	logic [WordW-1:0] total_q;
	logic [WordW-1:0] k_q;
	logic [WordW-1:0] acc_q;
	logic [WordW-1:0] out_q;
	logic             out_valid_q;
	logic             fin_q;
	logic             full_q;

	logic [WordW-1:0] in_word;
	logic [NvW-1:0]   in_nv_raw;
	logic [NvW-1:0]   in_nv;
	logic [WordW-1:0] in_mask;
	logic [WordW-1:0] inc;
	logic [WordW:0]   sum;
	logic [WordW-1:0] total_next;
	logic [WordW-1:0] k_rot;
	logic [WordW-1:0] h_x;
	logic [WordW-1:0] h_rot;
	logic [WordW-1:0] h_fold;
	logic [WordW-1:0] f_x;
	logic [WordW-1:0] a_x13;

	assign in_word   = s_tdata[WordW-1:0];
	assign in_nv_raw = s_tdata[WordW+NvW-1:WordW];
	assign in_nv     = in_nv_raw[2] ? FullNv : in_nv_raw;

	always_comb begin
		case (in_nv)
			3'd1:    in_mask = 32'h0000_00ff;
			3'd2:    in_mask = 32'h0000_ffff;
			3'd3:    in_mask = 32'h00ff_ffff;
			default: in_mask = 32'hffff_ffff;
		endcase
	end

	assign inc        = s_tlast ? {{(WordW-NvW){1'b0}}, in_nv} : 32'd4;
	assign sum        = {1'b0, total_q} + {1'b0, inc};
	assign total_next = sum[WordW] ? {WordW{1'b1}} : sum[WordW-1:0];

	assign k_rot  = {k_q[16:0], k_q[31:17]};
	assign h_x    = hash_q ^ k_q;
	assign h_rot  = {h_x[18:0], h_x[31:19]};
	assign h_fold = h_rot + {h_rot[29:0], 2'b00} + FoldN;
	assign f_x    = hash_q ^ total_q;
	assign a_x13  = acc_q ^ (acc_q >> 13);

	assign sts.in_last      = s_tlast;
	assign sts.in_has_bytes = (in_nv != 3'd0);
	assign sts.key_fin      = fin_q;
	assign sts.out_free     = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			hash_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			fin_q       <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seed_q <= cfg_data;
			end
			if (cmd.load) begin
				if (total_q == '0) begin
					hash_q <= seed_q;
				end
				total_q <= total_next;
				fin_q   <= s_tlast;
				full_q  <= !s_tlast || (in_nv == FullNv);
			end
			if (cmd.mix) begin
				hash_q <= full_q ? h_fold : h_x;
			end
			if (cmd.fin_out) begin
				total_q     <= '0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q <= s_tlast ? (in_word & in_mask) : in_word;
		end
		if (cmd.mul1) begin
			k_q <= k_q * MixC1;
		end
		if (cmd.mul2) begin
			k_q <= k_rot * MixC2;
		end
		if (cmd.fin0) begin
			acc_q <= f_x ^ (f_x >> 16);
		end
		if (cmd.fin1) begin
			acc_q <= acc_q * FinF1;
		end
		if (cmd.fin2) begin
			acc_q <= a_x13 * FinF2;
		end
		if (cmd.fin_out) begin
			out_q <= acc_q ^ (acc_q >> 16);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

### hw/rtl/murmur3_x86_32_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur3_x86_32_stream_hash
// murmurhash3 x86_32 over a key streamed as little-endian 32-bit words
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: key_word, valid_bytes; s_tlast: last
// m_*       out  m_tvalid/m_tready  m_tdata: hash_value
// cfg_*     in   cfg_valid/cfg_ready cfg_data: seed
//
// a non-last item steps through accept, two multiply steps and fold
// a last item goes on to finalization (with zero valid bytes it skips the block mix):
// the sequencer walks the block mix multipliers and then the two avalanche multipliers, one per cycle
// reset clears seed, running hash, byte count and output valid
// the result sits in an output register; the next item is accepted while it waits,
// and a further finish stalls only until that register is taken
// ----------------------------------------------------------------------------
module murmur3_x86_32_stream_hash
	import mm3h_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [InDataW-1:0] s_tdata,   // [31:0] key_word, [34:32] valid_bytes, [39:35] zero
	input  logic               s_tlast,   // last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [WordW-1:0]   m_tdata,   // [31:0] hash_value
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WordW-1:0]   cfg_data   // [31:0] seed
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mm3h_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mm3h_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
